>>> sv/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`endif

>>> sv/fbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types and codes of the frustum box cull block
// ----------------------------------------------------------------------------
package fbc_pkg;
	typedef enum logic [1:0] {
		MODE_LOAD_MV   = 2'd0,
		MODE_LOAD_PROJ = 2'd1,
		MODE_EXTRACT   = 2'd2,
		MODE_TEST      = 2'd3
	} mode_t;

	// controller to datapath commands
	typedef struct packed {
		logic       capture;   // latch input item
		logic       load_mv;
		logic       load_proj;
		logic       clip_mac;  // one mac step of clip element
		logic       clip_clr;
		logic       clip_done; // shift, saturate and store clip element
		logic [3:0] clip_idx;
		logic [1:0] k_idx;
		logic       plane_wr;  // write plane components for pair j
		logic [1:0] pair_j;
		logic       test_clr;
		logic       test_step; // eval plane p corners
		logic [2:0] plane_p;
	} fbc_cmd_t;

	typedef struct packed {
		logic culled;
	} fbc_sts_t;
endpackage
`default_nettype wire

>>> sv/fbc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_in_if / fbc_out_if
// valid-ready channels of the frustum box cull block
// ----------------------------------------------------------------------------
interface fbc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [3:0]         elem_index;
	logic signed [31:0] elem_value;
	logic signed [31:0] corner_a_x;
	logic signed [31:0] corner_a_y;
	logic signed [31:0] corner_a_z;
	logic signed [31:0] corner_b_x;
	logic signed [31:0] corner_b_y;
	logic signed [31:0] corner_b_z;
	modport source (output valid, mode, elem_index, elem_value, corner_a_x, corner_a_y,
		corner_a_z, corner_b_x, corner_b_y, corner_b_z, input ready);
	modport sink (input valid, mode, elem_index, elem_value, corner_a_x, corner_a_y,
		corner_a_z, corner_b_x, corner_b_y, corner_b_z, output ready);
endinterface

interface fbc_out_if;
	logic valid;
	logic ready;
	logic visible;
	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

>>> sv/fbc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_datapath
// matrix stores, clip mac unit, plane store and corner evaluation
// ----------------------------------------------------------------------------
module fbc_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fbc_pkg::fbc_cmd_t cmd,
	input  wire logic [3:0]        in_idx,
	input  wire logic signed [31:0] in_val,
	input  wire logic signed [31:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz,
	output fbc_pkg::fbc_sts_t      sts
);
	localparam int AW = 66;

	logic signed [31:0] mv_q [16];
	logic signed [31:0] pj_q [16];
	logic signed [31:0] clip_q [16];
	logic signed [32:0] pl_q [24];
	logic signed [31:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [AW-1:0] acc_q;
	logic signed [63:0]   prod_s1;
	logic                 prod_v_s1;
	logic [3:0]           pidx_s1;
	logic                 pdone_s1;
	logic                 culled_q;

	// clip mac: registered product then accumulate
	logic [1:0] rr, cc;
	assign rr = cmd.clip_idx[3:2];
	assign cc = cmd.clip_idx[1:0];

	logic signed [AW-1:0] acc_nx, shf;
	logic signed [31:0]   sat;
	always_comb begin
		acc_nx = acc_q + (prod_v_s1 ? AW'(prod_s1) : AW'(0));
		shf = acc_nx >>> FRAC_BITS;
		if (shf > AW'(64'sh7fffffff)) sat = 32'sh7fffffff;
		else if (shf < -AW'(64'sh80000000)) sat = 32'sh80000000;
		else sat = shf[31:0];
	end

	// corner dot products for one plane, eight corners in parallel
	logic signed [32:0] nx, ny, nz, dd;
	logic all_out;
	always_comb begin
		logic signed [31:0] x, y, z;
		logic signed [97:0] s;
		nx = pl_q[{cmd.plane_p, 2'd0}];
		ny = pl_q[{cmd.plane_p, 2'd1}];
		nz = pl_q[{cmd.plane_p, 2'd2}];
		dd = pl_q[{cmd.plane_p, 2'd3}];
		all_out = 1'b1;
		for (int m = 0; m < 8; m++) begin
			x = m[0] ? bx_q : ax_q;
			y = m[1] ? by_q : ay_q;
			z = m[2] ? bz_q : az_q;
			s = 98'(nx * x) + 98'(ny * y) + 98'(nz * z) + (98'(dd) <<< FRAC_BITS);
			if (s > 98'sd0) all_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mv_q[i] <= '0;
				pj_q[i] <= '0;
				clip_q[i] <= '0;
			end
			for (int i = 0; i < 24; i++) pl_q[i] <= '0;
			acc_q <= '0;
			prod_s1 <= '0;
			pidx_s1 <= '0;
			prod_v_s1 <= 1'b0;
			pdone_s1 <= 1'b0;
			culled_q <= 1'b0;
		end else begin
			if (cmd.load_mv) mv_q[in_idx] <= in_val;
			if (cmd.load_proj) pj_q[in_idx] <= in_val;
			prod_v_s1 <= cmd.clip_mac;
			pdone_s1 <= cmd.clip_done;
			pidx_s1 <= cmd.clip_idx;
			prod_s1 <= mv_q[{rr, cmd.k_idx}] * pj_q[{cmd.k_idx, cc}];
			if (pdone_s1) begin
				clip_q[pidx_s1] <= sat;
				acc_q <= '0;
			end else if (cmd.clip_clr) acc_q <= '0;
			else acc_q <= acc_nx;
			if (cmd.plane_wr) begin
				for (int k = 0; k < 4; k++) begin
					pl_q[{cmd.pair_j, 1'b0, 2'(k)}] <=
						33'(clip_q[4*k+3]) - 33'(clip_q[{2'(k), cmd.pair_j}]);
					pl_q[{cmd.pair_j, 1'b1, 2'(k)}] <=
						33'(clip_q[4*k+3]) + 33'(clip_q[{2'(k), cmd.pair_j}]);
				end
			end
			if (cmd.test_clr) culled_q <= 1'b0;
			else if (cmd.test_step && all_out) culled_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q <= in_ax; ay_q <= in_ay; az_q <= in_az;
			bx_q <= in_bx; by_q <= in_by; bz_q <= in_bz;
		end
	end

	assign sts.culled = culled_q;
endmodule
`default_nettype wire

>>> sv/fbc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_ctrl
// sequencer for load, extract and test items
// ----------------------------------------------------------------------------
module fbc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_mode,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_visible,
	output fbc_pkg::fbc_cmd_t      cmd,
	input  wire fbc_pkg::fbc_sts_t sts
);
	typedef enum logic [2:0] {S_IDLE, S_CLIP, S_DRAIN, S_PLANE, S_TEST, S_DONE} state_t;
	state_t     state_q;
	logic [5:0] cnt_q;
	logic       acc;

	assign in_ready = (state_q == S_IDLE) && !(out_valid && !out_ready);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.capture   = acc;
		cmd.load_mv   = acc && in_mode == fbc_pkg::MODE_LOAD_MV;
		cmd.load_proj = acc && in_mode == fbc_pkg::MODE_LOAD_PROJ;
		cmd.test_clr  = acc;
		cmd.clip_clr  = acc;
		cmd.clip_idx  = cnt_q[5:2];
		cmd.k_idx     = cnt_q[1:0];
		cmd.clip_mac  = state_q == S_CLIP;
		cmd.clip_done = state_q == S_CLIP && cnt_q[1:0] == 2'd3;
		cmd.plane_wr  = state_q == S_PLANE;
		cmd.pair_j    = cnt_q[1:0];
		cmd.test_step = state_q == S_TEST;
		cmd.plane_p   = cnt_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			out_visible <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (acc && in_mode == fbc_pkg::MODE_EXTRACT) state_q <= S_CLIP;
					else if (acc && in_mode == fbc_pkg::MODE_TEST) state_q <= S_TEST;
				end
				S_CLIP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					cnt_q <= '0;
					state_q <= S_PLANE;
				end
				S_PLANE: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd2) state_q <= S_IDLE;
				end
				S_TEST: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'd5) state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid <= 1'b1;
					out_visible <= !sts.culled;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/frustum_box_cull_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_cull_top
// view frustum plane extraction and box culling
// ----------------------------------------------------------------------------
// load item: written into its matrix store on acceptance; test item: one plane
// per cycle with all eight corners evaluated in parallel, result in the output register
// extract item: sequenced through the single clip mac unit (64 steps)
// reset: all matrices and planes clear to zero, no result pending
module frustum_box_cull_top #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	fbc_in_if.sink   in_ch,
	fbc_out_if.source out_ch
);
	fbc_pkg::fbc_cmd_t cmd;
	fbc_pkg::fbc_sts_t sts;

	// controller owns the handshakes
	fbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_visible(out_ch.visible),
		.cmd(cmd), .sts(sts)
	);

	// datapath holds all stores and arithmetic
	fbc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_idx(in_ch.elem_index), .in_val(in_ch.elem_value),
		.in_ax(in_ch.corner_a_x), .in_ay(in_ch.corner_a_y), .in_az(in_ch.corner_a_z),
		.in_bx(in_ch.corner_b_x), .in_by(in_ch.corner_b_y), .in_bz(in_ch.corner_b_z),
		.sts(sts)
	);
endmodule
`default_nettype wire

>>> sv/fbc_checker.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fbc_checker
// port level checks of the frustum box cull block
// ----------------------------------------------------------------------------
module fbc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [1:0] in_mode,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_visible
);
	`ASSERT_NEXT(a_load_no_result, clk, arst_n,
		in_valid && in_ready && in_mode != fbc_pkg::MODE_TEST && !out_valid, !out_valid)
	`ASSERT_NEXT(a_busy_after_test, clk, arst_n,
		in_valid && in_ready && in_mode == fbc_pkg::MODE_TEST, !in_ready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n,
		out_valid && !out_ready, out_valid && $stable(out_visible))
endmodule

bind frustum_box_cull_top fbc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_visible(out_ch.visible)
);
`default_nettype wire
